// ----- rtl/core/dclp_pkg.sv -----
// Shared types and constants for the display command list player.
package dclp_pkg;

    // Position inside the command list
    typedef enum logic [2:0] {
        PH_LEN,
        PH_DELAY,
        PH_CMD,
        PH_PAYLOAD,
        PH_ENDED
    } phase_t;

    localparam logic [1:0] KIND_SEND = 2'd0;
    localparam logic [1:0] KIND_WAIT = 2'd1;
    localparam logic [1:0] KIND_END  = 2'd2;

    localparam logic [7:0] DELAY_UNIT_RESET = 8'd5;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data_byte;
        logic        is_command;
        logic [15:0] delay_ms;
        logic        last;
    } result_t;

    typedef struct packed {
        phase_t      phase;
        logic [7:0]  bytes_left;
        logic [7:0]  held_delay;
    } walk_state_t;

    // Decode of one list byte: up to two results plus the next walk state
    typedef struct packed {
        logic        res0_valid;
        result_t     res0;
        logic        res1_valid;
        result_t     res1;
        walk_state_t state_next;
    } decode_t;

endpackage

// ----- rtl/core/dclp_decode.sv -----
// Per-byte decode of the command list: next state and the results a byte causes.
module dclp_decode (
    input  dclp_pkg::walk_state_t state,
    input  logic [7:0]            list_byte,
    input  logic [7:0]            delay_unit_ms,
    output dclp_pkg::decode_t     dec
);
    import dclp_pkg::*;

    logic [7:0]  left_dec;
    logic [15:0] wait_ms;

    assign left_dec = state.bytes_left - 8'd1;
    assign wait_ms  = {8'd0, state.held_delay} * {8'd0, delay_unit_ms};

    always_comb
    begin
        dec            = '0;
        dec.state_next = state;
        case (state.phase)
            PH_LEN:
            begin
                if (list_byte == 8'd0)
                begin
                    dec.res0_valid       = 1'b1;
                    dec.res0.kind        = KIND_END;
                    dec.res0.last        = 1'b1;
                    dec.state_next.phase = PH_ENDED;
                end
                else
                begin
                    dec.state_next.bytes_left = list_byte;
                    dec.state_next.phase      = PH_DELAY;
                end
            end
            PH_DELAY:
            begin
                dec.state_next.held_delay = list_byte;
                dec.state_next.phase      = PH_CMD;
            end
            PH_CMD, PH_PAYLOAD:
            begin
                dec.res0_valid            = 1'b1;
                dec.res0.kind             = KIND_SEND;
                dec.res0.data_byte        = list_byte;
                dec.res0.is_command       = (state.phase == PH_CMD);
                dec.state_next.bytes_left = left_dec;
                if (left_dec == 8'd0)
                begin
                    // record done: send, then release and wait
                    dec.res1_valid       = 1'b1;
                    dec.res1.kind        = KIND_WAIT;
                    dec.res1.delay_ms    = wait_ms;
                    dec.res1.last        = 1'b1;
                    dec.state_next.phase = PH_LEN;
                end
                else
                begin
                    dec.res0.last        = 1'b1;
                    dec.state_next.phase = PH_PAYLOAD;
                end
            end
            default:
            begin
                dec.state_next.phase = PH_ENDED;
            end
        endcase
    end

endmodule

// ----- rtl/core/display_command_list_player_core.sv -----
// Top level of the display command list player.
//
//  channel  | signals                                   | handshake
//  ---------+-------------------------------------------+-----------------------
//  cfg      | cfg_we, cfg_data (delay_unit_ms)          | write on cfg_we, no wait
//  in       | in_valid, in_ready, list_byte             | valid/ready
//  out      | out_valid, out_ready, kind, data_byte,    | valid/ready
//           | is_command, delay_ms, last                |
//
// One list byte is taken per cycle while in_ready is high; its results are registered.
// The last byte of a record makes two results (send, then wait); the second
// sits in a spare slot. While it waits, only bytes that make at most one result
// (length, delay, or anything after the end) are taken, and such a byte's
// result queues behind it, so with out_ready high the input does not stall.
// rst_n clears the walk state to "expect length byte" and the unit to 5 ms.
// A stalled output holds its item; input flows while the output register is leaving
// or empty, and the spare slot is empty or the next byte is a header or past the end.
module display_command_list_player_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  list_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [7:0]  data_byte,
    output logic        is_command,
    output logic [15:0] delay_ms,
    output logic        last
);
    import dclp_pkg::*;

    walk_state_t state_reg;
    logic [7:0]  unit_reg;
    decode_t     dec;

    // output register (a) and spare slot for the second result (b)
    result_t     a_reg, a_next;
    logic        a_valid_reg, a_valid_next;
    result_t     b_reg, b_next;
    logic        b_valid_reg, b_valid_next;

    logic        in_fire;
    logic        out_fire;
    logic        one_result_max;

    dclp_decode u_decode (
        .state         (state_reg),
        .list_byte     (list_byte),
        .delay_unit_ms (unit_reg),
        .dec           (dec)
    );

    // header bytes and bytes after the end never make more than one result
    assign one_result_max = state_reg.phase inside {PH_LEN, PH_DELAY, PH_ENDED};

    assign out_fire = a_valid_reg && out_ready;
    assign in_ready = (!a_valid_reg || out_ready) && (!b_valid_reg || one_result_max);
    assign in_fire  = in_valid && in_ready;

    always_comb
    begin
        a_next       = a_reg;
        a_valid_next = a_valid_reg && !out_fire;
        b_next       = b_reg;
        b_valid_next = b_valid_reg;
        if (b_valid_reg)
        begin
            if (out_fire)
            begin
                // spare slot moves up
                a_next       = b_reg;
                a_valid_next = 1'b1;
                b_valid_next = 1'b0;
            end
            if (in_fire && dec.res0_valid)
            begin
                // new item queues behind the one moving up
                b_next       = dec.res0;
                b_valid_next = 1'b1;
            end
        end
        else
        begin
            if (in_fire && dec.res0_valid)
            begin
                a_next       = dec.res0;
                a_valid_next = 1'b1;
            end
            if (in_fire && dec.res1_valid)
            begin
                b_next       = dec.res1;
                b_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase      <= PH_LEN;
            state_reg.bytes_left <= 8'd0;
            state_reg.held_delay <= 8'd0;
            unit_reg             <= DELAY_UNIT_RESET;
            a_valid_reg          <= 1'b0;
            b_valid_reg          <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                state_reg <= dec.state_next;
            end
            if (cfg_we)
            begin
                unit_reg <= cfg_data;
            end
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
    end

    assign out_valid  = a_valid_reg;
    assign kind       = a_reg.kind;
    assign data_byte  = a_reg.data_byte;
    assign is_command = a_reg.is_command;
    assign delay_ms   = a_reg.delay_ms;
    assign last       = a_reg.last;

    // spare slot is only ever filled behind the output register
    assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg |-> a_valid_reg)
        else $error("spare result held with empty output register");

    // once the list has ended it stays ended
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.phase == PH_ENDED) |=> (state_reg.phase == PH_ENDED))
        else $error("left ended phase without reset");

    // a command or payload byte always yields an output item next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (state_reg.phase == PH_CMD || state_reg.phase == PH_PAYLOAD))
        |=> (out_valid && kind == KIND_SEND))
        else $error("send byte lost");

    // a wait item always closes its byte's results
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind == KIND_WAIT) |-> last)
        else $error("wait item not marked last");

endmodule
